### rtl/core/adcp_pkg.sv
// Package for the audio DSP command port: port offsets, command codes,
// status bytes and the beat structs shared by all modules. No dependencies.
package adcp_pkg;

  localparam logic [3:0] PORT_RESET     = 4'd6;
  localparam logic [3:0] PORT_READ_DATA = 4'd10;
  localparam logic [3:0] PORT_COMMAND   = 4'd12;
  localparam logic [3:0] PORT_READ_STAT = 4'd14;

  localparam logic [7:0] ACK_BYTE       = 8'hAA;
  localparam logic [7:0] STATUS_READY   = 8'h80;
  localparam logic [7:0] STATUS_IDLE    = 8'h00;
  localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
  localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;
  localparam logic [7:0] CMD_SET_RATE   = 8'h41;
  localparam logic [7:0] CMD_PLAY_AUTO8 = 8'hC6;

  localparam logic [1:0] PARAMS_NONE    = 2'd0;
  localparam logic [1:0] PARAMS_ONE     = 2'd1;
  localparam logic [1:0] PARAMS_TWO     = 2'd2;
  localparam logic [1:0] PARAMS_THREE   = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [3:0] port_offset;
    logic [7:0] write_data;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        speaker_enabled;
    logic [15:0] output_rate;
    logic [15:0] block_length;
    logic        playback_active;
  } result_t;

endpackage

### rtl/core/audio_dsp_command_port.sv
// Top level of the audio DSP command port: input register, command core
// and result register. Depends on adcp_pkg, adcp_in_reg, adcp_core, adcp_out_reg.
//
//   channel  direction  handshake             beat fields
//   in       to block   in_valid / in_stall   mode, port_offset, write_data
//   out      from block out_valid / out_stall read_data, speaker_enabled,
//                                              output_rate, block_length,
//                                              playback_active
//
// One access per cycle unless in_stall is high; each accepted access passes
// through the input register, then the result register, before its result is valid.
// Reset (rst, synchronous) clears all command state and empties both stages.
// out_stall holds the result register; the input register keeps filling and
// in_stall is high only while both stages are full and out_stall is high.
module audio_dsp_command_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [3:0]  port_offset,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        speaker_enabled,
  output logic [15:0] output_rate,
  output logic [15:0] block_length,
  output logic        playback_active
);
  import adcp_pkg::*;

  access_t acc_in;
  access_t acc;
  logic    acc_valid;
  logic    out_ready;
  logic    fire;
  result_t res_next;
  result_t res;

  assign acc_in.mode        = mode;
  assign acc_in.port_offset = port_offset;
  assign acc_in.write_data  = write_data;

  assign fire = acc_valid && out_ready;

  adcp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .acc_in    (acc_in),
    .take      (out_ready),
    .acc_valid (acc_valid),
    .acc       (acc)
  );

  adcp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .acc  (acc),
    .res  (res_next)
  );

  adcp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (acc_valid),
    .res_in    (res_next),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign read_data       = res.read_data;
  assign speaker_enabled = res.speaker_enabled;
  assign output_rate     = res.output_rate;
  assign block_length    = res.block_length;
  assign playback_active = res.playback_active;

endmodule

### rtl/core/adcp_in_reg.sv
// Input register stage of the audio DSP command port.
// Holds one access beat until the core takes it. Depends on adcp_pkg.
module adcp_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  adcp_pkg::access_t acc_in,
  input  logic             take,
  output logic             acc_valid,
  output adcp_pkg::access_t acc
);
  import adcp_pkg::*;

  logic load;

  assign in_stall = acc_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (load) begin
      acc_valid <= 1'b1;
    end else if (take) begin
      acc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= acc_in;
    end
  end

endmodule

### rtl/core/adcp_core.sv
// Command processor state of the audio DSP command port: reset handshake,
// command parser and the result of each access. Depends on adcp_pkg.
module adcp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  adcp_pkg::access_t acc,
  output adcp_pkg::result_t res
);
  import adcp_pkg::*;

  logic        in_reset, in_reset_next;
  logic        byte_waiting, byte_waiting_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic [7:0]  current_command, current_command_next;
  logic [1:0]  params_left, params_left_next;
  logic [15:0] rate_reg, rate_reg_next;
  logic [7:0]  transfer_mode, transfer_mode_next;
  logic [15:0] length_reg, length_reg_next;
  logic        speaker_reg, speaker_reg_next;
  logic        playing_reg, playing_reg_next;
  logic [7:0]  rd;
  logic [7:0]  b;

  assign b = acc.write_data;

  always_comb begin
    in_reset_next        = in_reset;
    byte_waiting_next    = byte_waiting;
    pending_byte_next    = pending_byte;
    current_command_next = current_command;
    params_left_next     = params_left;
    rate_reg_next        = rate_reg;
    transfer_mode_next   = transfer_mode;
    length_reg_next      = length_reg;
    speaker_reg_next     = speaker_reg;
    playing_reg_next     = playing_reg;
    rd                   = STATUS_IDLE;

    if (acc.mode) begin
      if (acc.port_offset == PORT_RESET) begin
        if (b[0]) begin
          in_reset_next     = 1'b1;
          byte_waiting_next = 1'b0;
        end else if (in_reset) begin
          in_reset_next        = 1'b0;
          pending_byte_next    = ACK_BYTE;
          byte_waiting_next    = 1'b1;
          current_command_next = 8'h00;
          params_left_next     = PARAMS_NONE;
          playing_reg_next     = 1'b0;
        end
      end else if (acc.port_offset == PORT_COMMAND && !in_reset) begin
        if (params_left == PARAMS_NONE) begin
          current_command_next = b;
          unique case (b)
            CMD_SPK_ON: begin
              speaker_reg_next = 1'b1;
            end
            CMD_SPK_OFF: begin
              speaker_reg_next = 1'b0;
            end
            CMD_SET_RATE: begin
              params_left_next = PARAMS_TWO;
            end
            CMD_PLAY_AUTO8: begin
              params_left_next = PARAMS_THREE;
            end
            default: begin
            end
          endcase
        end else begin
          if (current_command == CMD_SET_RATE) begin
            if (params_left == PARAMS_TWO) begin
              rate_reg_next = {b, rate_reg[7:0]};
            end else begin
              rate_reg_next = {rate_reg[15:8], b};
            end
          end else if (current_command == CMD_PLAY_AUTO8) begin
            priority if (params_left == PARAMS_THREE) begin
              transfer_mode_next = b;
            end else if (params_left == PARAMS_TWO) begin
              length_reg_next = {length_reg[15:8], b};
            end else begin
              length_reg_next  = {b, length_reg[7:0]};
              playing_reg_next = 1'b1;
            end
          end
          params_left_next = params_left - PARAMS_ONE;
        end
      end
    end else begin
      if (acc.port_offset == PORT_READ_DATA) begin
        rd                = pending_byte;
        byte_waiting_next = 1'b0;
      end else if (acc.port_offset == PORT_READ_STAT) begin
        rd = byte_waiting ? STATUS_READY : STATUS_IDLE;
      end
    end
  end

  assign res.read_data       = rd;
  assign res.speaker_enabled = speaker_reg_next;
  assign res.output_rate     = rate_reg_next;
  assign res.block_length    = length_reg_next;
  assign res.playback_active = playing_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reset        <= 1'b0;
      byte_waiting    <= 1'b0;
      pending_byte    <= 8'h00;
      current_command <= 8'h00;
      params_left     <= PARAMS_NONE;
      rate_reg        <= 16'h0000;
      transfer_mode   <= 8'h00;
      length_reg      <= 16'h0000;
      speaker_reg     <= 1'b0;
      playing_reg     <= 1'b0;
    end else if (fire) begin
      in_reset        <= in_reset_next;
      byte_waiting    <= byte_waiting_next;
      pending_byte    <= pending_byte_next;
      current_command <= current_command_next;
      params_left     <= params_left_next;
      rate_reg        <= rate_reg_next;
      transfer_mode   <= transfer_mode_next;
      length_reg      <= length_reg_next;
      speaker_reg     <= speaker_reg_next;
      playing_reg     <= playing_reg_next;
    end
  end

endmodule

### rtl/core/adcp_out_reg.sv
// Result register of the audio DSP command port.
// Holds one result beat until the consumer takes it. Depends on adcp_pkg.
module adcp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  adcp_pkg::result_t res_in,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output adcp_pkg::result_t res
);
  import adcp_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res <= res_in;
    end
  end

endmodule

### test/audio_dsp_command_port_tb.sv
// Self-checking bench for audio_dsp_command_port: directed and random port accesses.
// A scoreboard class predicts each result beat in order. Depends on adcp_pkg and the RTL.
`timescale 1ns / 1ps

module audio_dsp_command_port_tb;
  import adcp_pkg::*;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  class adcp_port_tracker;
    logic        in_reset, byte_waiting, speaker_on, playing;
    logic [7:0]  pending_byte, command, transfer_mode;
    logic [1:0]  params_left;
    logic [15:0] rate, length;
    result_t     expected_replies[$];
    int          errors;

    function new();
      in_reset = 1'b0; byte_waiting = 1'b0; speaker_on = 1'b0; playing = 1'b0;
      pending_byte = '0; command = '0; transfer_mode = '0;
      params_left = PARAMS_NONE; rate = '0; length = '0; errors = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void take_command(logic [7:0] b);
      if (params_left == PARAMS_NONE) begin
        command = b;
        case (b)
          CMD_SPK_ON:     speaker_on = 1'b1;
          CMD_SPK_OFF:    speaker_on = 1'b0;
          CMD_SET_RATE:   params_left = PARAMS_TWO;
          CMD_PLAY_AUTO8: params_left = PARAMS_THREE;
          default: ;
        endcase
        return;
      end
      if (command == CMD_SET_RATE) begin
        if (params_left == PARAMS_TWO) rate[15:8] = b;
        else rate[7:0] = b;
      end else if (command == CMD_PLAY_AUTO8) begin
        if (params_left == PARAMS_THREE) begin
          transfer_mode = b;
        end else if (params_left == PARAMS_TWO) begin
          length[7:0] = b;
        end else begin
          length[15:8] = b;
          playing = 1'b1;
        end
      end
      params_left = params_left - 2'd1;
    endfunction

    function void note_access(logic m, logic [3:0] off, logic [7:0] d);
      result_t r;
      r = '0;
      if (m == ACC_WRITE) begin
        if (off == PORT_RESET) begin
          if (d[0]) begin
            in_reset = 1'b1;
            byte_waiting = 1'b0;
          end else if (in_reset) begin
            in_reset = 1'b0;
            pending_byte = ACK_BYTE;
            byte_waiting = 1'b1;
            command = '0;
            params_left = PARAMS_NONE;
            playing = 1'b0;
          end
        end else if (off == PORT_COMMAND && !in_reset) begin
          take_command(d);
        end
      end else if (off == PORT_READ_DATA) begin
        r.read_data = pending_byte;
        byte_waiting = 1'b0;
      end else if (off == PORT_READ_STAT) begin
        r.read_data = byte_waiting ? STATUS_READY : STATUS_IDLE;
      end
      r.speaker_enabled = speaker_on;
      r.output_rate = rate;
      r.block_length = length;
      r.playback_active = playing;
      expected_replies.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare("read_data", 32'(want.read_data), 32'(got.read_data));
      compare("speaker_enabled", 32'(want.speaker_enabled), 32'(got.speaker_enabled));
      compare("output_rate", 32'(want.output_rate), 32'(got.output_rate));
      compare("block_length", 32'(want.block_length), 32'(got.block_length));
      compare("playback_active", 32'(want.playback_active), 32'(got.playback_active));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [3:0]  port_offset;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic        speaker_enabled;
  logic [15:0] output_rate;
  logic [15:0] block_length;
  logic        playback_active;

  adcp_port_tracker tracker = new();
  int  sent = 0;
  bit  sender_calm = 1'b0;
  int  stall_left = 0;
  int  steady_left = 0;

  audio_dsp_command_port dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .port_offset(port_offset), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .speaker_enabled(speaker_enabled),
    .output_rate(output_rate), .block_length(block_length),
    .playback_active(playback_active)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    got = {read_data, speaker_enabled, output_rate, block_length, playback_active};
    if (!rst && in_valid && !in_stall) tracker.note_access(mode, port_offset, write_data);
    if (!rst && out_valid && !out_stall) tracker.check_reply(got);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (steady_left != 0) begin
      out_stall <= 1'b0;
      steady_left--;
    end else begin
      out_stall <= 1'b0;
      steady_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : pick_gap();
      stall_left = pick_gap();
    end
  end

  task automatic send_access(input logic m, input logic [3:0] off, input logic [7:0] d);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    port_offset <= off;
    write_data <= d;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic command_byte(input logic [7:0] d);
    send_access(ACC_WRITE, PORT_COMMAND, d);
  endtask

  task automatic reset_handshake(input bit poke_during);
    send_access(ACC_WRITE, PORT_RESET, {7'($urandom), 1'b1});
    if (poke_during) command_byte(8'($urandom));
    send_access(ACC_WRITE, PORT_RESET, {7'($urandom), 1'b0});
  endtask

  task automatic random_read();
    logic [3:0] off;
    case ($urandom_range(0, 3))
      0: off = PORT_READ_DATA;
      1: off = PORT_READ_STAT;
      2: off = PORT_COMMAND;
      default: off = 4'($urandom);
    endcase
    send_access(ACC_READ, off, 8'($urandom));
  endtask

  initial begin : stimulus
    int pick;
    int next_drain;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = ACC_READ;
    port_offset = '0;
    write_data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_access(ACC_READ, PORT_READ_STAT, 8'hFF);
    send_access(ACC_READ, PORT_READ_DATA, 8'h00);
    send_access(ACC_READ, PORT_COMMAND, 8'h55);
    send_access(ACC_READ, 4'd0, 8'hAA);
    send_access(ACC_WRITE, PORT_RESET, 8'h01);
    send_access(ACC_WRITE, PORT_RESET, 8'h00);
    send_access(ACC_READ, PORT_READ_STAT, 8'h00);
    send_access(ACC_READ, PORT_READ_DATA, 8'h00);
    send_access(ACC_READ, PORT_READ_STAT, 8'h00);
    send_access(ACC_WRITE, PORT_RESET, 8'h00);
    command_byte(CMD_SPK_ON);
    command_byte(CMD_SET_RATE);
    command_byte(8'hFF);
    command_byte(8'hFF);
    command_byte(CMD_PLAY_AUTO8);
    command_byte(8'hFF);
    command_byte(8'hFF);
    command_byte(8'hFF);
    command_byte(CMD_SPK_OFF);
    command_byte(8'h00);
    send_access(ACC_WRITE, 4'd15, 8'hAB);
    send_access(ACC_WRITE, PORT_RESET, 8'hFF);
    command_byte(CMD_SPK_ON);
    send_access(ACC_WRITE, PORT_RESET, 8'hFE);
    command_byte(CMD_SET_RATE);
    command_byte(8'h00);
    send_access(ACC_WRITE, PORT_RESET, 8'h01);
    send_access(ACC_WRITE, PORT_RESET, 8'h00);
    wait_for_replies();

    next_drain = sent + 150;
    while (sent < 700) begin
      if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        command_byte(CMD_SET_RATE);
        command_byte(8'($urandom));
        command_byte(8'($urandom));
      end else if (pick < 40) begin
        command_byte(CMD_PLAY_AUTO8);
        repeat (3) command_byte(8'($urandom));
      end else if (pick < 50) begin
        command_byte($urandom_range(0, 1) ? CMD_SPK_ON : CMD_SPK_OFF);
      end else if (pick < 60) begin
        reset_handshake($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) begin
          send_access(ACC_READ, PORT_READ_STAT, 8'($urandom));
          send_access(ACC_READ, PORT_READ_DATA, 8'($urandom));
          send_access(ACC_READ, PORT_READ_STAT, 8'($urandom));
        end
      end else if (pick < 75) begin
        random_read();
      end else if (pick < 85) begin
        send_access(ACC_WRITE, 4'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        command_byte($urandom_range(0, 1) ? CMD_SET_RATE : CMD_PLAY_AUTO8);
        repeat ($urandom_range(0, 2)) command_byte(8'($urandom));
        if ($urandom_range(0, 1)) reset_handshake(1'b0);
      end else begin
        send_access(1'($urandom), 4'($urandom), 8'($urandom));
      end
      if (sent >= next_drain) begin
        wait_for_replies();
        next_drain = sent + $urandom_range(100, 200);
      end
    end

    wait_for_replies();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("audio_dsp_command_port regression: pass");
    end else begin
      $display("audio_dsp_command_port regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("audio_dsp_command_port regression: fail");
    $finish;
  end

endmodule

### audio_dsp_command_port.f
rtl/core/adcp_pkg.sv
rtl/core/adcp_in_reg.sv
rtl/core/adcp_core.sv
rtl/core/adcp_out_reg.sv
rtl/core/audio_dsp_command_port.sv
test/audio_dsp_command_port_tb.sv
